>>> sv/mwf_pkg.sv
// Shared types and constants of the median window filter.
`timescale 1ns / 1ps
package mwf_pkg;

   localparam int MAX_WINDOW_DEF = 5;
   localparam int MAX_LINE_DEF   = 1024;
   localparam int MAX_LINES_DEF  = 1024;
   localparam int CHANNELS_DEF   = 4;

   localparam int SAMPLE_W  = 8;
   localparam int PORT_CHAN = 4;
   localparam int CFG_LEN_W = 11;
   localparam int CFG_WIN_W = 3;

   typedef enum logic [1:0] {
      CSR_LINE_LENGTH,
      CSR_LINE_COUNT,
      CSR_WINDOW_SIZE,
      CSR_CHANNEL_COUNT
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_FETCH,
      ST_LAST,
      ST_SELECT,
      ST_DONE
   } state_type;

   // lane control from the sequencer
   typedef struct packed {
      logic       clear;
      logic       load;
      logic       load_zero;
      logic       step;
      logic [2:0] bit_idx;
   } lane_ctl_type;

endpackage

>>> sv/median_window_filter.sv
// Top level of the streaming median window filter.
`timescale 1ns / 1ps
// Usage:
//   req_* carries one pixel (req_type = 0) or a drain beat (req_type = 1) with four
//   8-bit channel samples, in scan order: line_count lines of line_length pixels.
//   rsp_* carries the per-channel window median and rsp_frame_end on the last
//   result of the frame. Results trail the input by A*line_length + A pixels,
//   A = N-1-N/2; drain beats flush the tail. csr_* is an APB-style port:
//   line_length at 0x0, line_count at 0x4, window_size at 0x8, channel_count at
//   0xC. A write restarts the frame.
// Timing:
//   A beat that yields no result leaves the filter idle, ready for the next beat.
//   A beat that yields a result keeps req_ready low from its accept through the
//   address steps to the window's top left, one line-store read per window sample
//   (the single read port sets this), the read-latency state, eight bit-select
//   steps shared by all lanes in parallel, and the hand-off into the output register,
//   where the result shows at the end of that span when the register is free. A result
//   waiting in the output register does not block the next beat; only the next
//   result waits for the receiver, so a stalled receiver holds off the input.
// Reset: configuration returns to 1024, 1024, 3, 1 and both positions to zero;
//   req_ready stays low after reset and after each register write while the
//   geometry settles. The line store has no reset.
module median_window_filter #(
   parameter int MAX_WINDOW = mwf_pkg::MAX_WINDOW_DEF,
   parameter int MAX_LINE   = mwf_pkg::MAX_LINE_DEF,
   parameter int MAX_LINES  = mwf_pkg::MAX_LINES_DEF,
   parameter int CHANNELS   = mwf_pkg::CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_chan0,
   input  logic [7:0]  req_chan1,
   input  logic [7:0]  req_chan2,
   input  logic [7:0]  req_chan3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_med0,
   output logic [7:0]  rsp_med1,
   output logic [7:0]  rsp_med2,
   output logic [7:0]  rsp_med3,
   output logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW  = mwf_pkg::SAMPLE_W;
   localparam int PC  = mwf_pkg::PORT_CHAN;
   localparam int LEN = mwf_pkg::CFG_LEN_W;
   localparam int WNW = mwf_pkg::CFG_WIN_W;
   localparam int BUF = MAX_WINDOW * (MAX_LINE + 1);
   localparam int AW  = $clog2(BUF);
   localparam int Win = MAX_WINDOW * MAX_WINDOW;
   localparam int IW  = $clog2(Win);
   localparam int CW  = $clog2(Win + 1);
   localparam int NW  = $clog2(MAX_WINDOW + 1);
   localparam int LW  = $clog2(MAX_LINE + 1);
   localparam int HW  = $clog2(MAX_LINES + 1);
   localparam int CLW = $clog2(MAX_LINE);
   localparam int RHW = $clog2(MAX_LINES);
   localparam int PW  = $clog2(MAX_LINE * MAX_LINES + 1);

   // configuration
   logic [LEN-1:0] line_length_ff, line_length_in;
   logic [LEN-1:0] line_count_ff, line_count_in;
   logic [WNW-1:0] window_size_ff, window_size_in;
   logic [WNW-1:0] channel_count_ff, channel_count_in;
   logic           cfg_wr;
   logic [1:0]     settle_ff, settle_in;

   // clamped and derived frame geometry
   logic [LW-1:0] w_ff, w_in;
   logic [HW-1:0] h_ff, h_in;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] half_ff, a_ff;
   logic [PW-1:0] total_ff, delay_ff;
   logic [CW-1:0] nn_ff, rank0_ff;

   // frame positions
   logic [PW-1:0]  in_pos_ff, in_pos_in;
   logic [PW-1:0]  out_pos_ff, out_pos_in;
   logic [RHW-1:0] out_r_ff, out_r_in;
   logic [CLW-1:0] out_c_ff, out_c_in;
   logic [AW-1:0]  out_addr_ff, out_addr_in;
   logic [AW-1:0]  wr_addr_ff, wr_addr_in;

   // sequencer
   mwf_pkg::state_type state_ff, state_in;
   logic [NW-1:0] align_cnt_ff, align_cnt_in;
   logic [NW-1:0] kr_ff, kr_in, kc_ff, kc_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          fetch_v_ff, fetch_v_in;
   logic          fetch_zero_ff, fetch_zero_in;
   logic [IW-1:0] fetch_idx_ff, fetch_idx_in;
   logic [2:0]    bit_ff, bit_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_med_ff [PC];
   logic [SW-1:0] rsp_med_in [PC];
   logic          rsp_fe_ff, rsp_fe_in;

   // line store and lanes
   logic              mem_wr, mem_rd;
   logic [PC*SW-1:0]  mem_rd_data;
   mwf_pkg::lane_ctl_type lane_ctl;
   logic [SW-1:0]     lane_med [PC];

   logic          accept, in_done, pixel, emit, in_frame, frame_end;
   logic [AW+1:0] t_addr;
   int            rr, cc;

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (mwf_pkg::csr_idx_type'(csr_paddr[3:2]))
         mwf_pkg::CSR_LINE_LENGTH:   csr_prdata = 32'(line_length_ff);
         mwf_pkg::CSR_LINE_COUNT:    csr_prdata = 32'(line_count_ff);
         mwf_pkg::CSR_WINDOW_SIZE:   csr_prdata = 32'(window_size_ff);
         mwf_pkg::CSR_CHANNEL_COUNT: csr_prdata = 32'(channel_count_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_comb begin
      line_length_in   = line_length_ff;
      line_count_in    = line_count_ff;
      window_size_in   = window_size_ff;
      channel_count_in = channel_count_ff;
      if (cfg_wr) begin
         unique case (mwf_pkg::csr_idx_type'(csr_paddr[3:2]))
            mwf_pkg::CSR_LINE_LENGTH:   line_length_in   = csr_pwdata[LEN-1:0];
            mwf_pkg::CSR_LINE_COUNT:    line_count_in    = csr_pwdata[LEN-1:0];
            mwf_pkg::CSR_WINDOW_SIZE:   window_size_in   = csr_pwdata[WNW-1:0];
            mwf_pkg::CSR_CHANNEL_COUNT: channel_count_in = csr_pwdata[WNW-1:0];
            default:                    line_length_in   = line_length_ff;
         endcase
      end
   end

   // hold off the input until the derived geometry has caught up
   always_comb begin
      if (cfg_wr) begin
         settle_in = 2'd3;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // saturate the registers into the supported ranges
   always_comb begin
      if (line_length_ff == '0) begin
         w_in = LW'(1);
      end else if (int'(line_length_ff) > MAX_LINE) begin
         w_in = LW'(MAX_LINE);
      end else begin
         w_in = LW'(line_length_ff);
      end
      if (line_count_ff == '0) begin
         h_in = HW'(1);
      end else if (int'(line_count_ff) > MAX_LINES) begin
         h_in = HW'(MAX_LINES);
      end else begin
         h_in = HW'(line_count_ff);
      end
      if (window_size_ff == '0) begin
         n_in = NW'(1);
      end else if (int'(window_size_ff) > MAX_WINDOW) begin
         n_in = NW'(MAX_WINDOW);
      end else begin
         n_in = NW'(window_size_ff);
      end
   end

   // geometry settles after a register write: clamped values first, then derived ones
   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      h_ff     <= h_in;
      n_ff     <= n_in;
      half_ff  <= n_ff >> 1;
      a_ff     <= n_ff - NW'(1) - (n_ff >> 1);
      total_ff <= PW'(w_ff * h_ff);
      delay_ff <= PW'(a_ff * w_ff + a_ff);
      nn_ff    <= CW'(n_ff * n_ff);
      rank0_ff <= CW'(n_ff * n_ff) >> 1;
   end

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == mwf_pkg::ST_IDLE) && (settle_ff == 2'd0);
   assign in_done   = (in_pos_ff >= total_ff);
   assign pixel     = accept & ~in_done & ~req_type;
   assign emit      = accept & (in_done |
                      (~req_type & ((PW+1)'(in_pos_ff) + 1'b1 >
                                    (PW+1)'(out_pos_ff) + (PW+1)'(delay_ff))));
   assign frame_end = ((PW+1)'(out_pos_ff) + 1'b1 >= (PW+1)'(total_ff));

   assign rr       = int'(out_r_ff) + int'(kr_ff) - int'(half_ff);
   assign cc       = int'(out_c_ff) + int'(kc_ff) - int'(half_ff);
   assign in_frame = (rr >= 0) && (rr < int'(h_ff)) && (cc >= 0) && (cc < int'(w_ff));

   always_comb begin
      state_in      = state_ff;
      in_pos_in     = in_pos_ff;
      out_pos_in    = out_pos_ff;
      out_r_in      = out_r_ff;
      out_c_in      = out_c_ff;
      out_addr_in   = out_addr_ff;
      wr_addr_in    = wr_addr_ff;
      align_cnt_in  = align_cnt_ff;
      kr_in         = kr_ff;
      kc_in         = kc_ff;
      idx_in        = idx_ff;
      rd_addr_in    = rd_addr_ff;
      fetch_v_in    = 1'b0;
      fetch_zero_in = fetch_zero_ff;
      fetch_idx_in  = fetch_idx_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_fe_in     = rsp_fe_ff;
      rsp_med_in    = rsp_med_ff;
      mem_rd        = 1'b0;
      t_addr        = '0;
      lane_ctl      = '{clear: 1'b0, load: fetch_v_ff, load_zero: fetch_zero_ff,
                        step: 1'b0, bit_idx: bit_ff};

      unique case (state_ff)
         mwf_pkg::ST_IDLE: begin
            if (pixel) begin
               in_pos_in  = in_pos_ff + PW'(1);
               wr_addr_in = (int'(wr_addr_ff) == BUF - 1) ? '0 : wr_addr_ff + AW'(1);
            end
            if (emit) begin
               state_in     = mwf_pkg::ST_ALIGN;
               rd_addr_in   = out_addr_ff;
               align_cnt_in = '0;
               kr_in        = '0;
               kc_in        = '0;
               idx_in       = '0;
            end
         end
         mwf_pkg::ST_ALIGN: begin
            // step back N/2 lines and N/2 pixels to the window's top left
            lane_ctl.clear = 1'b1;
            if (align_cnt_ff == half_ff) begin
               state_in = mwf_pkg::ST_FETCH;
            end else begin
               t_addr = (AW+2)'(rd_addr_ff) + (AW+2)'(BUF) - (AW+2)'(w_ff) - (AW+2)'(1);
               if (int'(t_addr) >= BUF) begin
                  t_addr = t_addr - (AW+2)'(BUF);
               end
               rd_addr_in   = t_addr[AW-1:0];
               align_cnt_in = align_cnt_ff + NW'(1);
            end
         end
         mwf_pkg::ST_FETCH: begin
            mem_rd        = 1'b1;
            fetch_v_in    = 1'b1;
            fetch_zero_in = ~in_frame;
            fetch_idx_in  = idx_ff;
            idx_in        = idx_ff + IW'(1);
            if (kc_ff == n_ff - NW'(1)) begin
               kc_in  = '0;
               kr_in  = kr_ff + NW'(1);
               t_addr = (AW+2)'(rd_addr_ff) + (AW+2)'(BUF) + (AW+2)'(w_ff) + (AW+2)'(1)
                        - (AW+2)'(n_ff);
               if (int'(t_addr) >= 2 * BUF) begin
                  t_addr = t_addr - (AW+2)'(2 * BUF);
               end else if (int'(t_addr) >= BUF) begin
                  t_addr = t_addr - (AW+2)'(BUF);
               end
               rd_addr_in = t_addr[AW-1:0];
               if (kr_ff == n_ff - NW'(1)) begin
                  state_in = mwf_pkg::ST_LAST;
               end
            end else begin
               kc_in      = kc_ff + NW'(1);
               rd_addr_in = (int'(rd_addr_ff) == BUF - 1) ? '0 : rd_addr_ff + AW'(1);
            end
         end
         mwf_pkg::ST_LAST: begin
            // last sample lands in the lanes this cycle
            bit_in   = 3'd7;
            state_in = mwf_pkg::ST_SELECT;
         end
         mwf_pkg::ST_SELECT: begin
            lane_ctl.step = 1'b1;
            bit_in        = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = mwf_pkg::ST_DONE;
            end
         end
         mwf_pkg::ST_DONE: begin
            // merge the lanes into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_fe_in    = frame_end;
               for (int k = 0; k < PC; k++) begin
                  rsp_med_in[k] = (k < int'(channel_count_ff)) ? lane_med[k] : '0;
               end
               if (frame_end) begin
                  in_pos_in   = '0;
                  out_pos_in  = '0;
                  out_r_in    = '0;
                  out_c_in    = '0;
                  out_addr_in = '0;
                  wr_addr_in  = '0;
               end else begin
                  out_pos_in  = out_pos_ff + PW'(1);
                  out_addr_in = (int'(out_addr_ff) == BUF - 1) ? '0 : out_addr_ff + AW'(1);
                  if (int'(out_c_ff) == int'(w_ff) - 1) begin
                     out_c_in = '0;
                     out_r_in = out_r_ff + RHW'(1);
                  end else begin
                     out_c_in = out_c_ff + CLW'(1);
                  end
               end
               state_in = mwf_pkg::ST_IDLE;
            end
         end
         default: state_in = mwf_pkg::ST_IDLE;
      endcase

      // a register write restarts the frame
      if (cfg_wr) begin
         in_pos_in   = '0;
         out_pos_in  = '0;
         out_r_in    = '0;
         out_c_in    = '0;
         out_addr_in = '0;
         wr_addr_in  = '0;
      end
   end

   assign mem_wr = pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff   <= LEN'(1024);
         line_count_ff    <= LEN'(1024);
         window_size_ff   <= WNW'(3);
         channel_count_ff <= WNW'(1);
         settle_ff        <= 2'd3;
         in_pos_ff        <= '0;
         out_pos_ff       <= '0;
         out_r_ff         <= '0;
         out_c_ff         <= '0;
         out_addr_ff      <= '0;
         wr_addr_ff       <= '0;
         fetch_v_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         line_length_ff   <= line_length_in;
         line_count_ff    <= line_count_in;
         window_size_ff   <= window_size_in;
         channel_count_ff <= channel_count_in;
         settle_ff        <= settle_in;
         in_pos_ff        <= in_pos_in;
         out_pos_ff       <= out_pos_in;
         out_r_ff         <= out_r_in;
         out_c_ff         <= out_c_in;
         out_addr_ff      <= out_addr_in;
         wr_addr_ff       <= wr_addr_in;
         fetch_v_ff       <= fetch_v_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      align_cnt_ff  <= align_cnt_in;
      kr_ff         <= kr_in;
      kc_ff         <= kc_in;
      idx_ff        <= idx_in;
      rd_addr_ff    <= rd_addr_in;
      fetch_zero_ff <= fetch_zero_in;
      fetch_idx_ff  <= fetch_idx_in;
      bit_ff        <= bit_in;
      rsp_fe_ff     <= rsp_fe_in;
      rsp_med_ff    <= rsp_med_in;
   end

   mwf_line_store #(
      .Depth (BUF),
      .Width (PC * SW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr_ff),
      .wr_data ({req_chan3, req_chan2, req_chan1, req_chan0}),
      .rd_en   (mem_rd),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rd_data)
   );

   for (genvar k = 0; k < PC; k++) begin : g_lane
      if (k < CHANNELS) begin : g_on
         mwf_lane #(
            .MaxWindow (MAX_WINDOW)
         ) u_lane (
            .clock        (clock),
            .reset        (reset),
            .ctl          (lane_ctl),
            .load_idx     (fetch_idx_ff),
            .load_data    (mem_rd_data[k*SW +: SW]),
            .sample_count (nn_ff),
            .rank_init    (rank0_ff),
            .median       (lane_med[k])
         );
      end else begin : g_off
         assign lane_med[k] = '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_med0      = rsp_med_ff[0];
   assign rsp_med1      = rsp_med_ff[1];
   assign rsp_med2      = rsp_med_ff[2];
   assign rsp_med3      = rsp_med_ff[3];
   assign rsp_frame_end = rsp_fe_ff;

   a_fetch_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == mwf_pkg::ST_FETCH |-> CW'(idx_ff) < nn_ff)
      else $error("window fetch ran past the sample count");

   a_rd_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff != mwf_pkg::ST_IDLE |-> int'(rd_addr_ff) < BUF)
      else $error("line store read address out of range");

   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      out_pos_ff <= in_pos_ff)
      else $error("output position ahead of input position");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == mwf_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("finished result not placed in the output register");

endmodule

>>> sv/mwf_line_store.sv
// Pixel history memory: one write port, one registered read port.
`timescale 1ns / 1ps
module mwf_line_store #(
   parameter int Depth = 5125,
   parameter int Width = 32,
   localparam int AW = $clog2(Depth)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/mwf_lane.sv
// One channel lane: holds the window samples and picks the median bit by bit.
`timescale 1ns / 1ps
module mwf_lane #(
   parameter int MaxWindow = mwf_pkg::MAX_WINDOW_DEF,
   localparam int Win = MaxWindow * MaxWindow,
   localparam int IW  = $clog2(Win),
   localparam int CW  = $clog2(Win + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mwf_pkg::lane_ctl_type         ctl,
   input  logic [IW-1:0]                 load_idx,
   input  logic [mwf_pkg::SAMPLE_W-1:0]  load_data,
   input  logic [CW-1:0]                 sample_count,
   input  logic [CW-1:0]                 rank_init,
   output logic [mwf_pkg::SAMPLE_W-1:0]  median
);

   logic [mwf_pkg::SAMPLE_W-1:0] samples_ff [Win];
   logic [Win-1:0]               alive_ff, alive_in;
   logic [CW-1:0]                rank_ff, rank_in;
   logic [mwf_pkg::SAMPLE_W-1:0] med_ff, med_in;
   logic [Win-1:0]               bit_vec;
   logic [CW-1:0]                cnt0;

   always_comb begin
      cnt0 = '0;
      for (int i = 0; i < Win; i++) begin
         bit_vec[i] = samples_ff[i][ctl.bit_idx];
         cnt0 = cnt0 + CW'(alive_ff[i] & ~bit_vec[i]);
      end
      alive_in = alive_ff;
      rank_in  = rank_ff;
      med_in   = med_ff;
      if (ctl.clear) begin
         for (int i = 0; i < Win; i++) begin
            alive_in[i] = (CW'(i) < sample_count);
         end
         rank_in = rank_init;
      end else if (ctl.step) begin
         // keep only the candidates that agree with the chosen bit
         if (rank_ff < cnt0) begin
            med_in[ctl.bit_idx] = 1'b0;
            alive_in = alive_ff & ~bit_vec;
         end else begin
            med_in[ctl.bit_idx] = 1'b1;
            alive_in = alive_ff & bit_vec;
            rank_in  = rank_ff - cnt0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= '0;
         rank_ff  <= '0;
      end else begin
         alive_ff <= alive_in;
         rank_ff  <= rank_in;
      end
      med_ff <= med_in;
      if (ctl.load) begin
         samples_ff[load_idx] <= ctl.load_zero ? '0 : load_data;
      end
   end

   assign median = med_ff;

endmodule
